[rtl/trdr_pkg.sv]
// ----------------------------------------------------------------------------
// trdr_pkg
// Shared types and constants of the touch report decoder.
// ----------------------------------------------------------------------------
package trdr_pkg;

  localparam int unsigned REPORT_BYTES = 14;
  localparam int unsigned STORE_DEPTH  = REPORT_BYTES - 1;
  localparam int unsigned POS_W        = $clog2(REPORT_BYTES);

  // power of two, pointers wrap naturally
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [2:0] COUNT_MASK = 3'h7;
  localparam logic [3:0] NO_TOUCH_ID = 4'hF;

  localparam logic [15:0] WIDTH_RESET  = 16'd320;
  localparam logic [15:0] HEIGHT_RESET = 16'd480;
  localparam logic [2:0]  MAX_PTS_RESET = 3'd2;

  typedef enum logic [1:0] {
    CFG_ORIENTATION = 2'd0,
    CFG_WIDTH       = 2'd1,
    CFG_HEIGHT      = 2'd2,
    CFG_MAX_POINTS  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ORIENT_LRTB = 3'd0,
    ORIENT_LRBT = 3'd1,
    ORIENT_RLTB = 3'd2,
    ORIENT_RLBT = 3'd3,
    ORIENT_TBLR = 3'd4,
    ORIENT_BTLR = 3'd5,
    ORIENT_TBRL = 3'd6,
    ORIENT_BTRL = 3'd7
  } orient_e;

  typedef struct packed {
    logic [2:0]  orientation;
    logic [15:0] panel_width;
    logic [15:0] panel_height;
    logic [2:0]  max_points;
  } cfg_t;

  typedef struct packed {
    logic [7:0] ev_xh;
    logic [7:0] x_lo;
    logic [7:0] id_yh;
    logic [7:0] y_lo;
    logic [7:0] weight;
  } record_t;

  typedef struct packed {
    logic [7:0] gesture;
    logic [2:0] count;
    record_t    rec0;
    record_t    rec1;
  } frame_t;

  typedef struct packed {
    logic [1:0]  event_f;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  weight;
  } point_t;

  typedef struct packed {
    logic       frame_ok;
    logic [2:0] reported_count;
    logic [7:0] gesture;
    logic [1:0] points_found;
    point_t     pa;
    point_t     pb;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[rtl/trdr_front.sv]
// ----------------------------------------------------------------------------
// trdr_front
// Byte collector: gathers the report bytes and pushes one frame per report.
// ----------------------------------------------------------------------------
module trdr_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            report_byte_i,
  input  logic                  frame_start_i,
  input  trdr_pkg::queue_status_t q_status_i,
  output logic                  push_o,
  output trdr_pkg::frame_t      push_data_o
);

  logic [trdr_pkg::POS_W-1:0] pos_q, pos_d;
  logic [trdr_pkg::POS_W-1:0] eff_pos;
  logic [7:0]                 store_q [trdr_pkg::STORE_DEPTH];
  logic                       accept;
  logic                       last_byte;

  localparam logic [trdr_pkg::POS_W-1:0] LAST_POS = trdr_pkg::POS_W'(trdr_pkg::STORE_DEPTH);

  assign in_ready_o = (pos_q != LAST_POS) || !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign eff_pos    = frame_start_i ? '0 : pos_q;
  assign last_byte  = (eff_pos == LAST_POS);
  assign push_o     = accept && last_byte;

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (last_byte) begin
        pos_d = '0;
      end else begin
        pos_d = eff_pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !last_byte) begin
      store_q[eff_pos] <= report_byte_i;
    end
  end

  always_comb begin
    push_data_o.gesture      = store_q[0];
    push_data_o.count        = store_q[1][2:0] & trdr_pkg::COUNT_MASK;
    push_data_o.rec0.ev_xh   = store_q[2];
    push_data_o.rec0.x_lo    = store_q[3];
    push_data_o.rec0.id_yh   = store_q[4];
    push_data_o.rec0.y_lo    = store_q[5];
    push_data_o.rec0.weight  = store_q[6];
    push_data_o.rec1.ev_xh   = store_q[8];
    push_data_o.rec1.x_lo    = store_q[9];
    push_data_o.rec1.id_yh   = store_q[10];
    push_data_o.rec1.y_lo    = store_q[11];
    push_data_o.rec1.weight  = store_q[12];
  end

endmodule

[rtl/trdr_queue.sv]
// ----------------------------------------------------------------------------
// trdr_queue
// Short frame queue between the byte collector and the decode stage.
// ----------------------------------------------------------------------------
module trdr_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  trdr_pkg::frame_t        push_data_i,
  input  logic                    pop_i,
  output trdr_pkg::frame_t        pop_data_o,
  output trdr_pkg::queue_status_t status_o
);

  trdr_pkg::frame_t                 mem_q [trdr_pkg::QUEUE_DEPTH];
  logic [trdr_pkg::QUEUE_AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [trdr_pkg::QUEUE_AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [trdr_pkg::QUEUE_AW:0]      cnt_q, cnt_d;
  logic                             do_push, do_pop;

  localparam logic [trdr_pkg::QUEUE_AW:0] DEPTH_CNT =
    (trdr_pkg::QUEUE_AW+1)'(trdr_pkg::QUEUE_DEPTH);

  assign status_o.full  = (cnt_q == DEPTH_CNT);
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/trdr_back.sv]
// ----------------------------------------------------------------------------
// trdr_back
// Decode stage: maps and packs the point records, holds the result word.
// ----------------------------------------------------------------------------
module trdr_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  trdr_pkg::cfg_t          cfg_i,
  input  trdr_pkg::frame_t        frame_i,
  input  trdr_pkg::queue_status_t q_status_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output trdr_pkg::result_t       result_o
);

  logic              out_valid_q, out_valid_d;
  trdr_pkg::result_t out_q, out_d;
  trdr_pkg::point_t  p0, p1;
  logic              v0, v1, ok;

  function automatic trdr_pkg::point_t map_rec(trdr_pkg::record_t r, trdr_pkg::cfg_t c);
    logic [15:0]      rx, ry, wx, hy;
    trdr_pkg::point_t p;
    rx = {4'h0, r.ev_xh[3:0], r.x_lo};
    ry = {4'h0, r.id_yh[3:0], r.y_lo};
    wx = c.panel_width - rx;
    hy = c.panel_height - ry;
    p.event_f = r.ev_xh[7:6];
    p.weight  = r.weight;
    case (trdr_pkg::orient_e'(c.orientation))
      trdr_pkg::ORIENT_LRTB: begin p.x = rx; p.y = ry; end
      trdr_pkg::ORIENT_LRBT: begin p.x = rx; p.y = hy; end
      trdr_pkg::ORIENT_RLTB: begin p.x = wx; p.y = ry; end
      trdr_pkg::ORIENT_RLBT: begin p.x = wx; p.y = hy; end
      trdr_pkg::ORIENT_TBLR: begin p.x = ry; p.y = rx; end
      trdr_pkg::ORIENT_BTLR: begin p.x = ry; p.y = wx; end
      trdr_pkg::ORIENT_TBRL: begin p.x = hy; p.y = rx; end
      default:               begin p.x = hy; p.y = wx; end
    endcase
    return p;
  endfunction

  assign pop_o       = !q_status_i.empty && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

  always_comb begin
    p0 = map_rec(frame_i.rec0, cfg_i);
    p1 = map_rec(frame_i.rec1, cfg_i);
    v0 = (frame_i.rec0.id_yh[7:4] != trdr_pkg::NO_TOUCH_ID);
    v1 = (frame_i.rec1.id_yh[7:4] != trdr_pkg::NO_TOUCH_ID);
    ok = (frame_i.count != 3'd0) && (frame_i.count <= cfg_i.max_points);

    out_d                = '0;
    out_d.reported_count = frame_i.count;
    if (ok) begin
      out_d.frame_ok     = 1'b1;
      out_d.gesture      = frame_i.gesture;
      out_d.points_found = {1'b0, v0} + {1'b0, v1};
      if (v0) begin
        out_d.pa = p0;
        if (v1) begin
          out_d.pb = p1;
        end
      end else if (v1) begin
        out_d.pa = p1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

endmodule

[rtl/touch_report_decode_rotate_core.sv]
// ----------------------------------------------------------------------------
// touch_report_decode_rotate_core
// Touch controller point report decoder with orientation mapping.
// ----------------------------------------------------------------------------
// Takes one report byte per cycle while in_ready_o is high; every 14th byte
// (or the 14th after a frame_start) closes a report, and its result word
// passes through the frame queue and the output register to the output.
// A two-frame queue sits between the byte collector and the decode stage, so
// input only stalls on byte position 13 of a report while that queue is full;
// the decode stage and its output register retire one result per cycle while out_ready_i is high.
// Configuration writes are taken at any time through cfg_we_i and should be
// done while the block is idle.
module touch_report_decode_rotate_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  report_byte_i,
  input  logic        frame_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        frame_ok_o,
  output logic [2:0]  reported_count_o,
  output logic [7:0]  gesture_o,
  output logic [1:0]  points_found_o,
  output logic [1:0]  event_a_o,
  output logic [15:0] x_a_o,
  output logic [15:0] y_a_o,
  output logic [7:0]  weight_a_o,
  output logic [1:0]  event_b_o,
  output logic [15:0] x_b_o,
  output logic [15:0] y_b_o,
  output logic [7:0]  weight_b_o
);

  trdr_pkg::cfg_t          cfg_q, cfg_d;
  trdr_pkg::queue_status_t q_status;
  trdr_pkg::frame_t        push_data, pop_data;
  trdr_pkg::result_t       result;
  logic                    push, pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (trdr_pkg::cfg_idx_e'(cfg_addr_i))
        trdr_pkg::CFG_ORIENTATION: cfg_d.orientation  = cfg_wdata_i[2:0];
        trdr_pkg::CFG_WIDTH:       cfg_d.panel_width  = cfg_wdata_i;
        trdr_pkg::CFG_HEIGHT:      cfg_d.panel_height = cfg_wdata_i;
        default:                   cfg_d.max_points   = cfg_wdata_i[2:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.orientation  <= trdr_pkg::ORIENT_LRTB;
      cfg_q.panel_width  <= trdr_pkg::WIDTH_RESET;
      cfg_q.panel_height <= trdr_pkg::HEIGHT_RESET;
      cfg_q.max_points   <= trdr_pkg::MAX_PTS_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  trdr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .report_byte_i (report_byte_i),
    .frame_start_i (frame_start_i),
    .q_status_i    (q_status),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  trdr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  trdr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .frame_i     (pop_data),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign frame_ok_o       = result.frame_ok;
  assign reported_count_o = result.reported_count;
  assign gesture_o        = result.gesture;
  assign points_found_o   = result.points_found;
  assign event_a_o        = result.pa.event_f;
  assign x_a_o            = result.pa.x;
  assign y_a_o            = result.pa.y;
  assign weight_a_o       = result.pa.weight;
  assign event_b_o        = result.pb.event_f;
  assign x_b_o            = result.pb.x;
  assign y_b_o            = result.pb.y;
  assign weight_b_o       = result.pb.weight;

endmodule

[tb/trdr_report_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trdr_report_checker
// Watches the byte, result and configuration ports of the touch report
// decoder, keeps its own copy of the report store and registers, predicts
// one decoded word per closed report and compares each result word with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module trdr_report_checker
  import trdr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  report_byte_i,
  input  logic        frame_start_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        frame_ok_i,
  input  logic [2:0]  reported_count_i,
  input  logic [7:0]  gesture_i,
  input  logic [1:0]  points_found_i,
  input  logic [1:0]  event_a_i,
  input  logic [15:0] x_a_i,
  input  logic [15:0] y_a_i,
  input  logic [7:0]  weight_a_i,
  input  logic [1:0]  event_b_i,
  input  logic [15:0] x_b_i,
  input  logic [15:0] y_b_i,
  input  logic [7:0]  weight_b_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);

  cfg_t                         setup;
  logic [POS_W-1:0]             byte_pos;
  logic [STORE_DEPTH-1:0][7:0]  report_bytes;
  result_t                      decoded_reports[$];
  int unsigned                  mismatches = 0;
  int unsigned                  words_seen = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = decoded_reports.size();

  function automatic point_t place_point(input logic [7:0] ev_xh, input logic [7:0] x_lo,
                                         input logic [7:0] id_yh, input logic [7:0] y_lo,
                                         input logic [7:0] weight, input cfg_t c);
    logic [15:0] rx;
    logic [15:0] ry;
    logic [15:0] wx;
    logic [15:0] hy;
    point_t      p;
    rx = {4'h0, ev_xh[3:0], x_lo};
    ry = {4'h0, id_yh[3:0], y_lo};
    wx = c.panel_width - rx;
    hy = c.panel_height - ry;
    p.event_f = ev_xh[7:6];
    p.weight  = weight;
    case (orient_e'(c.orientation))
      ORIENT_LRTB: begin p.x = rx; p.y = ry; end
      ORIENT_LRBT: begin p.x = rx; p.y = hy; end
      ORIENT_RLTB: begin p.x = wx; p.y = ry; end
      ORIENT_RLBT: begin p.x = wx; p.y = hy; end
      ORIENT_TBLR: begin p.x = ry; p.y = rx; end
      ORIENT_BTLR: begin p.x = ry; p.y = wx; end
      ORIENT_TBRL: begin p.x = hy; p.y = rx; end
      default:     begin p.x = hy; p.y = wx; end
    endcase
    return p;
  endfunction

  function automatic result_t decode_report(input logic [STORE_DEPTH-1:0][7:0] rb,
                                            input cfg_t c);
    result_t    res;
    point_t     p;
    logic [2:0] count;
    logic [1:0] found;
    res   = '0;
    count = rb[1][2:0] & COUNT_MASK;
    res.reported_count = count;
    if (count != 3'd0 && count <= c.max_points) begin
      res.frame_ok = 1'b1;
      res.gesture  = rb[0];
      found = 2'd0;
      if (rb[4][7:4] != NO_TOUCH_ID) begin
        res.pa = place_point(rb[2], rb[3], rb[4], rb[5], rb[6], c);
        found  = 2'd1;
      end
      if (rb[10][7:4] != NO_TOUCH_ID) begin
        p = place_point(rb[8], rb[9], rb[10], rb[11], rb[12], c);
        if (found == 2'd0) res.pa = p;
        else res.pb = p;
        found = found + 2'd1;
      end
      res.points_found = found;
    end
    return res;
  endfunction

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("word %0d: %s expected %0h, got %0h", words_seen, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      setup.orientation  = ORIENT_LRTB;
      setup.panel_width  = WIDTH_RESET;
      setup.panel_height = HEIGHT_RESET;
      setup.max_points   = MAX_PTS_RESET;
      byte_pos           = '0;
      report_bytes       = '0;
      decoded_reports.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_ORIENTATION: setup.orientation  = cfg_wdata_i[2:0];
          CFG_WIDTH:       setup.panel_width  = cfg_wdata_i;
          CFG_HEIGHT:      setup.panel_height = cfg_wdata_i;
          default:         setup.max_points   = cfg_wdata_i[2:0];
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (decoded_reports.size() == 0) begin
          if (mismatches < 10) $display("word %0d: result with none expected", words_seen);
          mismatches++;
        end else begin
          want = decoded_reports.pop_front();
          check_field("frame_ok", 16'(want.frame_ok), 16'(frame_ok_i));
          check_field("reported_count", 16'(want.reported_count), 16'(reported_count_i));
          check_field("gesture", 16'(want.gesture), 16'(gesture_i));
          check_field("points_found", 16'(want.points_found), 16'(points_found_i));
          check_field("event_a", 16'(want.pa.event_f), 16'(event_a_i));
          check_field("x_a", want.pa.x, x_a_i);
          check_field("y_a", want.pa.y, y_a_i);
          check_field("weight_a", 16'(want.pa.weight), 16'(weight_a_i));
          check_field("event_b", 16'(want.pb.event_f), 16'(event_b_i));
          check_field("x_b", want.pb.x, x_b_i);
          check_field("y_b", want.pb.y, y_b_i);
          check_field("weight_b", 16'(want.pb.weight), 16'(weight_b_i));
        end
        words_seen++;
      end
      if (in_valid_i && in_ready_i) begin
        if (frame_start_i) byte_pos = '0;
        if (byte_pos < STORE_DEPTH) begin
          report_bytes[byte_pos] = report_byte_i;
          byte_pos = byte_pos + 1'b1;
        end else begin
          // closing byte carries only the unused misc field
          byte_pos = '0;
          decoded_reports.push_back(decode_report(report_bytes, setup));
        end
      end
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Byte stream stimulus for the touch report decoder: a short directed
// report, then ten register settings with random reports, cut-short
// reports and loose bytes, random gaps on both ports and a cycle watchdog.
// ----------------------------------------------------------------------------
module tb_top;
  import trdr_pkg::*;

  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_BYTES = 135;
  localparam int unsigned IDLE_LIMIT  = 2000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_addr_i    = CFG_ORIENTATION;
  logic [15:0] cfg_wdata_i   = '0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [7:0]  report_byte_i = '0;
  logic        frame_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic        frame_ok_o;
  logic [2:0]  reported_count_o;
  logic [7:0]  gesture_o;
  logic [1:0]  points_found_o;
  logic [1:0]  event_a_o;
  logic [15:0] x_a_o;
  logic [15:0] y_a_o;
  logic [7:0]  weight_a_o;
  logic [1:0]  event_b_o;
  logic [15:0] x_b_o;
  logic [15:0] y_b_o;
  logic [7:0]  weight_b_o;

  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned sent_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_stall = 0;
  logic [2:0]  max_pts = MAX_PTS_RESET;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  logic        out_taken = 1'b0;

  always #4 clk_i = ~clk_i;

  touch_report_decode_rotate_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .report_byte_i    (report_byte_i),
    .frame_start_i    (frame_start_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_ok_o       (frame_ok_o),
    .reported_count_o (reported_count_o),
    .gesture_o        (gesture_o),
    .points_found_o   (points_found_o),
    .event_a_o        (event_a_o),
    .x_a_o            (x_a_o),
    .y_a_o            (y_a_o),
    .weight_a_o       (weight_a_o),
    .event_b_o        (event_b_o),
    .x_b_o            (x_b_o),
    .y_b_o            (y_b_o),
    .weight_b_o       (weight_b_o)
  );

  trdr_report_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .report_byte_i    (report_byte_i),
    .frame_start_i    (frame_start_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_ok_i       (frame_ok_o),
    .reported_count_i (reported_count_o),
    .gesture_i        (gesture_o),
    .points_found_i   (points_found_o),
    .event_a_i        (event_a_o),
    .x_a_i            (x_a_o),
    .y_a_i            (y_a_o),
    .weight_a_i       (weight_a_o),
    .event_b_i        (event_b_o),
    .x_b_i            (x_b_o),
    .y_b_i            (y_b_o),
    .weight_b_i       (weight_b_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // result side: random stall after every word taken
  always @(posedge clk_i) out_taken <= out_valid_o && out_ready_i;

  always @(negedge clk_i) begin
    if (out_taken) begin
      if ($urandom_range(0, 7) == 0) rx_calm = !rx_calm;
      rx_stall = rx_calm ? 0 : $urandom_range(0, 17);
    end
    if (rx_stall > 0) begin
      out_ready_i <= 1'b0;
      rx_stall--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic mark);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    report_byte_i <= b;
    frame_start_i <= mark;
    do @(posedge clk_i); while (!in_ready_o);
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic send_report(input int unsigned length, input bit mark);
    logic [REPORT_BYTES-1:0][7:0] rep;
    int unsigned                  lim;
    lim = (max_pts == 3'd0) ? 1 : max_pts;
    for (int i = 0; i < REPORT_BYTES; i++) rep[i] = 8'($urandom);
    if ($urandom_range(0, 9) < 7) rep[1][2:0] = 3'($urandom_range(1, lim));
    if ($urandom_range(0, 3) == 0) rep[4][7:4] = NO_TOUCH_ID;
    if ($urandom_range(0, 3) == 0) rep[10][7:4] = NO_TOUCH_ID;
    tx_calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < length; i++) send_byte(rep[i], (i == 0) && mark);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
  endtask

  task automatic program_setup(input logic [2:0] orient, input logic [15:0] w,
                               input logic [15:0] h, input logic [2:0] maxp);
    write_reg(CFG_ORIENTATION, 16'(orient));
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_MAX_POINTS, 16'(maxp));
    cfg_we_i <= 1'b0;
    max_pts = maxp;
  endtask

  initial begin
    logic [2:0]  orient;
    logic [15:0] w;
    logic [15:0] h;
    logic [2:0]  maxp;
    int unsigned pick;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // cut-short report, then a full one with the first record empty
    send_byte(8'h5A, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hF9, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'hF7, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        settle();
        orient = 3'(phase - 1);
        w      = 16'($urandom);
        h      = 16'($urandom);
        maxp   = 3'($urandom_range(1, 7));
        case (phase)
          1: begin w = 16'h0000; h = 16'h0000; maxp = 3'd7; end
          2: begin w = 16'hFFFF; h = 16'hFFFF; maxp = 3'd1; end
          3: maxp = 3'd0;
          5: begin w = 16'h0000; h = 16'hFFFF; maxp = 3'd7; end
          6: begin w = 16'hFFFF; h = 16'h0000; maxp = 3'd2; end
          9: begin orient = ORIENT_BTRL; w = 16'hFFFF; h = 16'hFFFF; end
          default: ;
        endcase
        program_setup(orient, w, h, maxp);
      end
      while (sent_count < (phase + 1) * PHASE_BYTES) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          send_report(REPORT_BYTES, $urandom_range(0, 6) != 0);
        end else if (pick < 87) begin
          send_report($urandom_range(1, REPORT_BYTES - 1), 1'b1);
        end else begin
          tx_calm = 1'b0;
          repeat ($urandom_range(1, 5)) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
        end
      end
    end

    settle();
    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
